### sv/dta_pkg.sv
// ----------------------------------------------------------------------------
// dta_pkg : shared types, constants and calendar tables
// Widths of the date-time adder, the flags of the shared subtractor and the
// Gregorian month tables.
// ----------------------------------------------------------------------------
package dta_pkg;

	// width of the seconds offset
	localparam int ADD_BITS = 32;
	// accumulator holds the total seconds: offset plus time of day
	localparam int TOT_W = ADD_BITS + 1;
	// whole days carried out of the seconds sum
	localparam int DAY_W = ADD_BITS - 15;
	// working year, wide enough for the true result year
	localparam int YR_W = (DAY_W > 21) ? DAY_W - 6 : 15;
	// widest shift used by the division steps
	localparam int K_MAX = (DAY_W - 1 > 5) ? DAY_W - 1 : 5;
	localparam int KW = $clog2(K_MAX + 1);

	localparam int SECS_PER_DAY = 86400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN = 60;
	localparam int YEARS_PER_ERA = 400;
	localparam int DAYS_PER_YEAR = 365;
	localparam int MONTHS = 12;

	typedef logic [TOT_W-1:0] acc_t;

	typedef struct packed {
		logic ge;	// a >= b
		logic gt;	// a > b
	} sub_flags_t;

	// leap year from the year modulo 400
	function automatic logic is_leap(input logic [8:0] y400);
		logic leap;
		leap = (y400[1:0] == 2'd0) && (y400 != 9'd100) && (y400 != 9'd200)
			&& (y400 != 9'd300);
		return leap;
	endfunction

	// length of month m (1..12)
	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
		logic [4:0] len;
		unique case (m)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// days in the year before the first of month m (1..12)
	function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] m);
		logic [8:0] cum;
		unique case (m)
			4'd2:    cum = 9'd31;
			4'd3:    cum = 9'd59;
			4'd4:    cum = 9'd90;
			4'd5:    cum = 9'd120;
			4'd6:    cum = 9'd151;
			4'd7:    cum = 9'd181;
			4'd8:    cum = 9'd212;
			4'd9:    cum = 9'd243;
			4'd10:   cum = 9'd273;
			4'd11:   cum = 9'd304;
			4'd12:   cum = 9'd334;
			default: cum = 9'd0;
		endcase
		if (leap && m > 4'd2) begin
			cum = cum + 9'd1;
		end
		return cum;
	endfunction

endpackage

### sv/dta_sub.sv
// ----------------------------------------------------------------------------
// dta_sub : shared subtract and compare unit
// Gives a - b together with greater-or-equal and greater-than flags; every
// division step, year step and month step of the sequencer goes through it.
// ----------------------------------------------------------------------------
module dta_sub (
	input  dta_pkg::acc_t       a,
	input  dta_pkg::acc_t       b,
	output dta_pkg::acc_t       diff,
	output dta_pkg::sub_flags_t flags
);
	import dta_pkg::*;

	logic [TOT_W:0] wide;

	// subtract with borrow out
	assign wide = {1'b0, a} - {1'b0, b};
	assign diff = wide[TOT_W-1:0];
	assign flags.ge = ~wide[TOT_W];
	assign flags.gt = ~wide[TOT_W] && (wide[TOT_W-1:0] != '0);

endmodule

### sv/datetime_add_seconds.sv
// ----------------------------------------------------------------------------
// datetime_add_seconds : Gregorian date and time plus a count of seconds
// Sums the time of day and the offset, divides out days, hours and minutes,
// then steps whole years and walks the months to find the new date.
// ----------------------------------------------------------------------------
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+-------------
//  in      | in_valid/in_ready, start_*, add_seconds         | into block
//  out     | out_valid/out_ready, new_*, year_overflow       | out of block
//
//  One item at a time through the shared subtractor in dta_sub. An item goes
//  through a load, DAY_W (17) day-division steps, 5 hour, 6 minute and 6
//  year-modulo steps, a day-of-year step, the year stepping, the month walk
//  and a hand-over. Reset clears the sequencer and the output valid.
//  A result held by out_ready low keeps the block from loading the next item.
// ----------------------------------------------------------------------------
module datetime_add_seconds (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [13:0]                  start_year,
	input  logic [3:0]                   start_month,
	input  logic [4:0]                   start_day,
	input  logic [4:0]                   start_hour,
	input  logic [5:0]                   start_minute,
	input  logic [5:0]                   start_second,
	input  logic [dta_pkg::ADD_BITS-1:0] add_seconds,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [13:0]                  new_year,
	output logic [3:0]                   new_month,
	output logic [4:0]                   new_day,
	output logic [4:0]                   new_hour,
	output logic [5:0]                   new_minute,
	output logic [5:0]                   new_second,
	output logic                         year_overflow
);
	import dta_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DDAY, S_DHOUR, S_DMIN, S_YMOD, S_DOY, S_YEAR, S_MON, S_DONE
	} state_t;

	state_t           state_q;
	acc_t             acc_q;
	logic [KW-1:0]    k_q;
	logic [DAY_W-1:0] days_q;
	logic [4:0]       hour_q;
	logic [5:0]       min_q;
	logic [5:0]       sec_q;
	logic [YR_W-1:0]  year_q;
	logic [8:0]       y400_q;
	logic [3:0]       smon_q;
	logic [4:0]       sday_q;
	logic [3:0]       month_q;

	logic [13:0]      new_year_q;
	logic [3:0]       new_month_q;
	logic [4:0]       new_day_q;
	logic [4:0]       new_hour_q;
	logic [5:0]       new_minute_q;
	logic [5:0]       new_second_q;
	logic             year_overflow_q;
	logic             out_valid_q;

	acc_t             sub_b;
	acc_t             sub_diff;
	sub_flags_t       sub_flags;
	acc_t             acc_step;
	acc_t             tot_sec;
	logic             leap_now;
	logic             ovf;

	// time of day plus offset, in seconds
	assign tot_sec = TOT_W'(add_seconds)
		+ TOT_W'(start_hour) * TOT_W'(SECS_PER_HOUR)
		+ TOT_W'(start_minute) * TOT_W'(SECS_PER_MIN)
		+ TOT_W'(start_second);

	assign leap_now = is_leap(y400_q);

	// pick the second operand of the shared unit
	always_comb begin
		unique case (state_q)
			S_DDAY:  sub_b = acc_t'(SECS_PER_DAY) << k_q;
			S_DHOUR: sub_b = acc_t'(SECS_PER_HOUR) << k_q;
			S_DMIN:  sub_b = acc_t'(SECS_PER_MIN) << k_q;
			S_YMOD:  sub_b = acc_t'(YEARS_PER_ERA) << k_q;
			S_YEAR:  sub_b = acc_t'(DAYS_PER_YEAR) + acc_t'(leap_now);
			S_MON:   sub_b = acc_t'(month_len(leap_now, month_q));
			default: sub_b = '0;
		endcase
	end

	dta_sub u_sub (
		.a     (acc_q),
		.b     (sub_b),
		.diff  (sub_diff),
		.flags (sub_flags)
	);

	// restoring division step: keep the difference when it does not go negative
	assign acc_step = sub_flags.ge ? sub_diff : acc_q;

	// sequencer, datapath and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// drop a taken result unless the next one is handed over now
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					// take the item, clamp month and day
					if (in_valid) begin
						acc_q  <= tot_sec;
						year_q <= YR_W'(start_year);
						if (start_month == 4'd0) begin
							smon_q <= 4'd1;
						end else if (start_month > 4'(MONTHS)) begin
							smon_q <= 4'(MONTHS);
						end else begin
							smon_q <= start_month;
						end
						sday_q  <= (start_day == 5'd0) ? 5'd1 : start_day;
						k_q     <= KW'(DAY_W - 1);
						state_q <= S_DDAY;
					end
				end
				S_DDAY: begin
					acc_q  <= acc_step;
					days_q <= {days_q[DAY_W-2:0], sub_flags.ge};
					if (k_q == '0) begin
						k_q     <= KW'(4);
						state_q <= S_DHOUR;
					end else begin
						k_q <= k_q - KW'(1);
					end
				end
				S_DHOUR: begin
					acc_q  <= acc_step;
					hour_q <= {hour_q[3:0], sub_flags.ge};
					if (k_q == '0) begin
						k_q     <= KW'(5);
						state_q <= S_DMIN;
					end else begin
						k_q <= k_q - KW'(1);
					end
				end
				S_DMIN: begin
					min_q <= {min_q[4:0], sub_flags.ge};
					if (k_q == '0) begin
						// remainder is the seconds; load the year for its era
						sec_q   <= acc_step[5:0];
						acc_q   <= TOT_W'(year_q);
						k_q     <= KW'(5);
						state_q <= S_YMOD;
					end else begin
						acc_q <= acc_step;
						k_q   <= k_q - KW'(1);
					end
				end
				S_YMOD: begin
					acc_q <= acc_step;
					if (k_q == '0) begin
						y400_q  <= acc_step[8:0];
						state_q <= S_DOY;
					end else begin
						k_q <= k_q - KW'(1);
					end
				end
				S_DOY: begin
					// carried days plus the start date as a day of its year
					acc_q <= TOT_W'(days_q) + TOT_W'(cum_days(leap_now, smon_q))
						+ TOT_W'(sday_q);
					state_q <= S_YEAR;
				end
				S_YEAR: begin
					// step off whole years
					if (sub_flags.gt) begin
						acc_q  <= sub_diff;
						year_q <= year_q + YR_W'(1);
						y400_q <= (y400_q == 9'(YEARS_PER_ERA - 1)) ? 9'd0 : y400_q + 9'd1;
					end else begin
						month_q <= 4'd1;
						state_q <= S_MON;
					end
				end
				S_MON: begin
					// walk the months
					if (month_q < 4'(MONTHS) && sub_flags.gt) begin
						acc_q   <= sub_diff;
						month_q <= month_q + 4'd1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hand the result over once the output register is free
					if (!out_valid_q || out_ready) begin
						new_year_q      <= ovf ? '1 : year_q[13:0];
						new_month_q     <= month_q;
						new_day_q       <= acc_q[4:0];
						new_hour_q      <= hour_q;
						new_minute_q    <= min_q;
						new_second_q    <= sec_q;
						year_overflow_q <= ovf;
						out_valid_q     <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign ovf = |year_q[YR_W-1:14];

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign new_year      = new_year_q;
	assign new_month     = new_month_q;
	assign new_day       = new_day_q;
	assign new_hour      = new_hour_q;
	assign new_minute    = new_minute_q;
	assign new_second    = new_second_q;
	assign year_overflow = year_overflow_q;

	// an accepted item keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("block ready right after taking an item");

	// a delivered month and day are in range
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> new_month >= 4'd1 && new_month <= 4'd12 && new_day != 5'd0)
		else $error("result month or day out of range");

	// a delivered time of day is in range
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> new_hour < 5'd24 && new_minute < 6'd60 && new_second < 6'd60)
		else $error("result time of day out of range");

	// overflow saturates the year
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && year_overflow |-> new_year == 14'h3FFF)
		else $error("year overflow without saturated year");

	// month walk never passes December
	a_month_walk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MON |-> month_q >= 4'd1 && month_q <= 4'd12)
		else $error("month counter out of range");

endmodule

### tb/tb_datetime_add_seconds.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_datetime_add_seconds : self-checking bench for the date-time adder
// A queue of start dates and offsets feeds a valid/ready driver. A monitor
// compares every result, field by field, with a calendar predictor that
// walks days, years and months in software. It runs a directed set, then
// random items under four idling phases on both channels.
// ----------------------------------------------------------------------------
module tb_datetime_add_seconds;

	localparam int ADD_W        = dta_pkg::ADD_BITS;
	localparam int YEAR_LIMIT   = 16383;
	localparam int STALL_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 200;
	localparam int PHASE_ITEMS  = 160;
	localparam int PRINT_LIMIT  = 40;

	typedef struct packed {
		logic [13:0]      year;
		logic [3:0]       month;
		logic [4:0]       day;
		logic [4:0]       hour;
		logic [5:0]       minute;
		logic [5:0]       second;
		logic [ADD_W-1:0] offset;
	} dt_item_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        ovf;
	} dt_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [13:0] new_year;
	logic [3:0]  new_month;
	logic [4:0]  new_day;
	logic [4:0]  new_hour;
	logic [5:0]  new_minute;
	logic [5:0]  new_second;
	logic        year_overflow;

	dt_item_t   held_item = '0;
	dt_item_t   pending_items[$];
	dt_result_t expected_dates[$];
	dt_result_t seen_date;
	dt_result_t wanted_date;

	int in_idle_pct = 0;
	int out_stall_pct = 0;
	int mismatches = 0;
	int items_sent = 0;
	int directed_items = 0;
	int dates_checked = 0;
	int saturated_years = 0;
	int quiet_cycles = 0;

	datetime_add_seconds dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.start_year    (held_item.year),
		.start_month   (held_item.month),
		.start_day     (held_item.day),
		.start_hour    (held_item.hour),
		.start_minute  (held_item.minute),
		.start_second  (held_item.second),
		.add_seconds   (held_item.offset),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.new_year      (new_year),
		.new_month     (new_month),
		.new_day       (new_day),
		.new_hour      (new_hour),
		.new_minute    (new_minute),
		.new_second    (new_second),
		.year_overflow (year_overflow)
	);

	// Gregorian rule: every fourth year, but centuries only every fourth one
	function automatic bit leap_year(input longint unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int month_days(input bit leap, input longint unsigned m);
		int len;
		case (m)
			2:           len = leap ? 29 : 28;
			4, 6, 9, 11: len = 30;
			default:     len = 31;
		endcase
		return len;
	endfunction

	// expected date and time after the offset
	function automatic dt_result_t add_offset(input dt_item_t it);
		longint unsigned yr, mo, dy, days, secs, m, off;
		dt_result_t r;
		yr = it.year;
		mo = it.month;
		dy = it.day;
		off = it.offset;
		// clamp month and day; out-of-range time fields just carry
		if (mo < 1) mo = 1;
		if (mo > 12) mo = 12;
		if (dy < 1) dy = 1;
		days = off / dta_pkg::SECS_PER_DAY;
		secs = longint'(it.hour) * dta_pkg::SECS_PER_HOUR
			+ longint'(it.minute) * dta_pkg::SECS_PER_MIN + longint'(it.second)
			+ off % dta_pkg::SECS_PER_DAY;
		days += secs / dta_pkg::SECS_PER_DAY;
		secs = secs % dta_pkg::SECS_PER_DAY;
		// day of the start year, 1-based
		for (m = 1; m < mo; m++) days += month_days(leap_year(yr), m);
		days += dy;
		// step off whole years, then walk the months
		while (days > 365 + leap_year(yr)) begin
			days -= 365 + leap_year(yr);
			yr++;
		end
		m = 1;
		while (m < 12 && days > month_days(leap_year(yr), m)) begin
			days -= month_days(leap_year(yr), m);
			m++;
		end
		r.ovf    = (yr > YEAR_LIMIT);
		r.year   = r.ovf ? 14'(YEAR_LIMIT) : yr[13:0];
		r.month  = m[3:0];
		r.day    = days[4:0];
		r.hour   = 5'(secs / dta_pkg::SECS_PER_HOUR);
		r.minute = 6'((secs % dta_pkg::SECS_PER_HOUR) / dta_pkg::SECS_PER_MIN);
		r.second = 6'(secs % dta_pkg::SECS_PER_MIN);
		return r;
	endfunction

	task automatic queue_item(input int y, input int mo, input int d, input int h,
			input int mi, input int s, input logic [ADD_W-1:0] off);
		dt_item_t it;
		it.year   = y[13:0];
		it.month  = mo[3:0];
		it.day    = d[4:0];
		it.hour   = h[4:0];
		it.minute = mi[5:0];
		it.second = s[5:0];
		it.offset = off;
		pending_items.push_back(it);
	endtask

	function automatic logic [ADD_W-1:0] random_offset();
		logic [63:0] wide;
		logic [ADD_W-1:0] off;
		wide = {$urandom, $urandom};
		case ($urandom_range(5))
			0:       off = ADD_W'($urandom_range(dta_pkg::SECS_PER_DAY - 1));
			1:       off = ADD_W'($urandom_range(40 * dta_pkg::SECS_PER_DAY));
			2:       off = ADD_W'(longint'($urandom_range(49000)) * dta_pkg::SECS_PER_DAY);
			3:       off = '1 - ADD_W'($urandom_range(200000));
			default: off = wide[ADD_W-1:0];
		endcase
		return off;
	endfunction

	// mostly well-formed dates with random content, some raw noise
	function automatic dt_item_t random_item();
		dt_item_t it;
		int y;
		if ($urandom_range(99) < 15) begin
			it.year   = 14'($urandom_range(16383));
			it.month  = 4'($urandom_range(15));
			it.day    = 5'($urandom_range(31));
			it.hour   = 5'($urandom_range(31));
			it.minute = 6'($urandom_range(63));
			it.second = 6'($urandom_range(63));
		end else begin
			case ($urandom_range(9))
				0:       y = 16000 + $urandom_range(383);
				1:       y = 100 * $urandom_range(99) + $urandom_range(2) - 1;
				default: y = $urandom_range(9999);
			endcase
			if (y < 0) y = 0;
			it.year   = 14'(y);
			it.month  = 4'($urandom_range(12, 1));
			it.day    = 5'($urandom_range(month_days(leap_year(y), it.month), 1));
			it.hour   = 5'($urandom_range(23));
			it.minute = 6'($urandom_range(59));
			it.second = 6'($urandom_range(59));
		end
		it.offset = random_offset();
		return it;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_LIMIT) $display("MISMATCH %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// drive the next item once the current one is taken; record its prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_dates.push_back(add_offset(held_item));
				items_sent++;
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
					held_item <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// take results and compare with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				seen_date = '{new_year, new_month, new_day, new_hour, new_minute,
					new_second, year_overflow};
				if (expected_dates.size() == 0) begin
					report_mismatch("result with no item outstanding");
				end else begin
					wanted_date = expected_dates.pop_front();
					check_field("new_year", int'(seen_date.year), int'(wanted_date.year));
					check_field("new_month", int'(seen_date.month),
						int'(wanted_date.month));
					check_field("new_day", int'(seen_date.day), int'(wanted_date.day));
					check_field("new_hour", int'(seen_date.hour), int'(wanted_date.hour));
					check_field("new_minute", int'(seen_date.minute),
						int'(wanted_date.minute));
					check_field("new_second", int'(seen_date.second),
						int'(wanted_date.second));
					check_field("year_overflow", int'(seen_date.ovf), int'(wanted_date.ovf));
					dates_checked++;
					if (wanted_date.ovf) saturated_years++;
				end
			end
			out_ready <= ($urandom_range(99) >= out_stall_pct);
		end
	end

	// watchdog: give up after a long stretch with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("datetime_add_seconds test failed");
					$finish;
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, clamps, carries and leap rules
		queue_item(0, 1, 1, 0, 0, 0, '0);
		queue_item(16383, 15, 31, 31, 63, 63, '1);
		queue_item(2023, 0, 15, 12, 0, 0, ADD_W'(3600));
		queue_item(2023, 13, 10, 0, 0, 0, ADD_W'(86400));
		queue_item(2023, 5, 0, 0, 0, 0, '0);
		queue_item(2023, 2, 31, 0, 0, 0, '0);
		queue_item(2021, 4, 30, 31, 63, 63, '0);
		queue_item(1999, 12, 31, 23, 59, 59, ADD_W'(1));
		queue_item(1900, 2, 28, 0, 0, 0, ADD_W'(86400));
		queue_item(2000, 2, 28, 0, 0, 0, ADD_W'(86400));
		queue_item(2024, 2, 28, 12, 30, 30, ADD_W'(86400));
		queue_item(2100, 2, 28, 23, 59, 59, ADD_W'(1));
		queue_item(9999, 12, 31, 23, 59, 59, '1);
		queue_item(16383, 1, 1, 0, 0, 0, '0);
		queue_item(16383, 12, 31, 23, 59, 59, ADD_W'(1));
		queue_item(16300, 6, 15, 8, 0, 0, '1);
		queue_item(2010, 7, 4, 0, 0, 0, ADD_W'(86399));
		queue_item(2010, 7, 4, 0, 0, 1, ADD_W'(86399));
		queue_item(1, 1, 1, 0, 0, 0, ADD_W'(365 * 86400));
		queue_item(10922, 5, 10, 10, 42, 21, ADD_W'({ADD_W/2{2'b10}}));
		queue_item(5461, 10, 21, 21, 21, 42, ADD_W'({ADD_W/2{2'b01}}));
		directed_items = pending_items.size();
		while (pending_items.size() > 0) @(negedge clk);

		// random items under each idling phase
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
				1:       begin in_idle_pct = 66; out_stall_pct = 0;  end
				2:       begin in_idle_pct = 0;  out_stall_pct = 66; end
				default: begin in_idle_pct = 17; out_stall_pct = 17; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) pending_items.push_back(random_item());
			while (pending_items.size() > 0) @(negedge clk);
		end

		// drain, then let any stray result show itself
		while (in_valid || expected_dates.size() > 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Ran %0d items (%0d directed) through four idling phases.",
			items_sent, directed_items);
		$display("Checked %0d results, %0d with a saturated year; %0d mismatches.",
			dates_checked, saturated_years, mismatches);
		if (mismatches == 0) begin
			$display("datetime_add_seconds test passed");
		end else begin
			$display("datetime_add_seconds test failed");
		end
		$finish;
	end

endmodule

### filelist.f
sv/dta_pkg.sv
sv/dta_sub.sv
sv/datetime_add_seconds.sv
tb/tb_datetime_add_seconds.sv
